// File: sv/mee_pkg.sv
// ----------------------------------------------------------------------------
// mee_pkg: shared types and constants of the exception entry unit
// Request kinds, register indexes, vector addresses and the state record.
// ----------------------------------------------------------------------------
package mee_pkg;

  // request kinds carried on the input tuser
  localparam logic [2:0] REQ_EXC  = 3'd0;
  localparam logic [2:0] REQ_TLBL = 3'd1;
  localparam logic [2:0] REQ_TLBS = 3'd2;
  localparam logic [2:0] REQ_INT  = 3'd3;
  localparam logic [2:0] REQ_TICK = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_STATUS  = 2'd0;
  localparam logic [1:0] CFG_COMPARE = 2'd1;
  localparam logic [1:0] CFG_PTBASE  = 2'd2;
  localparam logic [1:0] CFG_ASID    = 2'd3;

  // status bit positions
  localparam int ST_IE    = 0;
  localparam int ST_EXL   = 1;
  localparam int ST_ERL   = 2;
  localparam int ST_TIMER = 15;
  localparam int ST_EIE   = 16;
  localparam int ST_BEV   = 22;
  localparam int ST_DEV   = 23;

  localparam logic [31:0] STATUS_RESET = 32'h7040_0004;

  localparam logic [31:0] VEC_NORMAL = 32'h8000_0000;
  localparam logic [31:0] VEC_BOOT   = 32'hBFC0_0200;
  localparam logic [31:0] VEC_RESET  = 32'hBFC0_0000;

  localparam logic [31:0] OFS_TLB    = 32'h0000_0000;
  localparam logic [31:0] OFS_GEN    = 32'h0000_0180;
  localparam logic [31:0] OFS_INT    = 32'h0000_0200;
  localparam logic [31:0] OFS_ERL_A  = 32'h0000_0080;
  localparam logic [31:0] OFS_ERL_B  = 32'h0000_0100;

  localparam logic [23:0] CODE_TLBL  = 24'h00_0008;
  localparam logic [23:0] CODE_TLBS  = 24'h00_000C;
  localparam logic [23:0] CODE_TIMER = 24'h80_8000;
  localparam logic [23:0] EXC_MASK   = 24'h00_007C;
  localparam logic [23:0] ERL_MASK   = 24'h03_8000;
  localparam logic [23:0] ERL_RESET_MAX = 24'h00_8000;
  localparam logic [23:0] ERL_CODE_A = 24'h01_0000;
  localparam logic [23:0] ERL_CODE_B = 24'h01_8000;

  localparam logic [31:0] CTX_KEEP   = 32'hFF80_000F;
  localparam logic [31:0] CTX_VPN    = 32'h007F_FFF0;
  localparam logic [31:0] EHI_VPN    = 32'hFFFF_E000;
  localparam logic [31:0] TIMER_WINDOW = 32'd1000;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [23:0] exc_code;
    logic        in_delay_slot;
    logic [31:0] fault_addr;
    logic [31:0] cur_pc;
    logic [31:0] elapsed_cycles;
  } item_t;

  typedef struct packed {
    logic [31:0] status;
    logic [31:0] compare;
    logic        exl;
    logic [31:0] epc;
    logic [31:0] cause;
    logic [31:0] badvaddr;
    logic [31:0] context_w;
    logic [31:0] entryhi;
    logic [31:0] count;
  } cop0_t;

  typedef struct packed {
    logic        taken;
    logic [31:0] next_pc;
  } redirect_t;

endpackage

// File: sv/mee_entry.sv
// ----------------------------------------------------------------------------
// mee_entry: exception entry decision
// From the current COP0 state and one event, computes the next state and the
// redirect target. Purely combinational.
// ----------------------------------------------------------------------------
module mee_entry
  import mee_pkg::*;
(
  input  cop0_t     st,
  input  item_t     item,
  output cop0_t     st_nxt,
  output redirect_t redir
);

  logic        go;
  logic [23:0] code;
  logic [31:0] base_pc;
  logic [31:0] count_sum;
  logic [31:0] limit;
  logic        tick_hit;
  logic        int_en;
  logic        erl;
  logic [23:0] exc_bits;
  logic [23:0] erl_bits;
  logic        reset_vec;
  logic        normal;
  logic [31:0] offset;
  cop0_t       st_pre;

  assign count_sum = st.count + item.elapsed_cycles;
  assign limit     = st.compare + TIMER_WINDOW;
  assign tick_hit  = st.status[ST_TIMER] && (count_sum >= st.compare) && (count_sum < limit);
  assign int_en    = (|(st.status & {8'h00, item.exc_code})) && st.status[ST_EIE]
                     && st.status[ST_IE] && !st.exl && !st.status[ST_ERL];

  // event decode, TLB side effects and the Count update of timer ticks
  always_comb begin
    st_pre  = st;
    go      = 1'b0;
    code    = item.exc_code;
    base_pc = item.cur_pc;
    case (item.req_type) inside
      REQ_EXC: begin
        go = 1'b1;
      end
      REQ_TLBL, REQ_TLBS: begin
        st_pre.badvaddr  = item.fault_addr;
        st_pre.context_w = (st.context_w & CTX_KEEP) | ((item.fault_addr >> 9) & CTX_VPN);
        st_pre.entryhi   = (item.fault_addr & EHI_VPN) | (st.entryhi & ~EHI_VPN);
        code    = (item.req_type == REQ_TLBL) ? CODE_TLBL : CODE_TLBS;
        base_pc = item.cur_pc - 32'd4;
        go      = 1'b1;
      end
      REQ_INT: begin
        go = int_en;
      end
      REQ_TICK: begin
        st_pre.count = count_sum;
        code         = CODE_TIMER;
        go           = tick_hit;
      end
      default: ;
    endcase
  end

  assign erl       = st.status[ST_ERL];
  assign exc_bits  = code & EXC_MASK;
  assign erl_bits  = code & ERL_MASK;
  assign reset_vec = erl && (erl_bits <= ERL_RESET_MAX);
  assign normal    = erl ? !st.status[ST_DEV] : !st.status[ST_BEV];

  // vector offset
  always_comb begin
    offset = OFS_GEN;
    if (st.exl) begin
      offset = OFS_GEN;
    end else if (!erl) begin
      if (exc_bits == CODE_TLBL || exc_bits == CODE_TLBS) begin
        offset = OFS_TLB;
      end else if (exc_bits == 24'h0) begin
        offset = OFS_INT;
      end else begin
        offset = OFS_GEN;
      end
    end else begin
      if (erl_bits == ERL_CODE_A) begin
        offset = OFS_ERL_A;
      end else if (erl_bits == ERL_CODE_B) begin
        offset = OFS_ERL_B;
      end else begin
        offset = OFS_TLB;
      end
    end
  end

  // register updates of the entry itself
  always_comb begin
    cop0_t s;
    s = st_pre;
    redir.taken   = go;
    redir.next_pc = item.cur_pc;
    if (go) begin
      s.cause = {16'h0000, code[15:0]};
      if (reset_vec) begin
        redir.next_pc = VEC_RESET;
      end else begin
        if (!st.exl) begin
          s.exl            = 1'b1;
          s.status[ST_EXL] = 1'b1;
          s.epc            = item.in_delay_slot ? (base_pc - 32'd4) : base_pc;
          s.cause[31]      = item.in_delay_slot;
        end
        redir.next_pc = (normal ? VEC_NORMAL : VEC_BOOT) + offset;
      end
    end
    st_nxt = s;
  end

endmodule

// File: sv/mips_exception_entry_unit_core.sv
// ----------------------------------------------------------------------------
// mips_exception_entry_unit_core: COP0 exception entry unit
// Takes events (exceptions, TLB misses, interrupt checks, timer ticks),
// updates EPC/Cause/BadVAddr/Context/EntryHi/Count/EXL and reports the vector.
// ----------------------------------------------------------------------------
//  channel | ports                        | payload
//  --------+------------------------------+------------------------------------
//  in      | in_tvalid/in_tready          | tuser: req_type; tdata: event fields
//  out     | out_tvalid/out_tready        | tuser: taken; tdata: pc and COP0 regs
//  cfg     | cfg_valid/cfg_ready          | cfg_index, cfg_data (always ready)
//
//  One event per cycle sustained while the output is not stalled.
//  The event waits in an input register, the entry logic runs from it into the
//  output register, and COP0 state updates on that same edge.
//  A stalled output holds; the input register still takes one more beat.
//  rst_n (synchronous) restores Status to 0x70400004 and clears the other COP0 registers and both valid flags.
// ----------------------------------------------------------------------------
module mips_exception_entry_unit_core
  import mee_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // exc_code[23:0], in_delay_slot[24], fault_addr[56:25],
                                   // cur_pc[88:57], elapsed_cycles[120:89], zero pad
  input  logic [2:0]   in_tuser,   // req_type[2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [231:0] out_tdata,  // next_pc[31:0], epc_out[63:32], cause_out[95:64],
                                   // badvaddr_out[127:96], context_out[159:128],
                                   // entryhi_out[191:160], count_out[223:192],
                                   // exl_out[224], zero pad
  output logic [0:0]   out_tuser,  // taken[0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic      in_valid_r;
  item_t     item_r;
  logic      out_valid_r;
  logic [231:0] out_data_r;
  logic      out_user_r;
  cop0_t     st_r;
  cop0_t     st_nxt;
  redirect_t redir;
  logic      advance;
  logic      in_fire;
  logic      cfg_fire;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  mee_entry u_entry (
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .redir  (redir)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_fire) begin
      item_r.req_type       <= in_tuser;
      item_r.exc_code       <= in_tdata[23:0];
      item_r.in_delay_slot  <= in_tdata[24];
      item_r.fault_addr     <= in_tdata[56:25];
      item_r.cur_pc         <= in_tdata[88:57];
      item_r.elapsed_cycles <= in_tdata[120:89];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      out_user_r <= redir.taken;
      out_data_r <= {7'b0, st_nxt.exl, st_nxt.count, st_nxt.entryhi, st_nxt.context_w,
                     st_nxt.badvaddr, st_nxt.cause, st_nxt.epc, redir.next_pc};
    end
  end

  // COP0 state: the user must let configuration writes arrive only while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // Status sits in the top bits of the record
      st_r <= {STATUS_RESET, {($bits(cop0_t) - 32){1'b0}}};
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_STATUS: begin
          st_r.status <= cfg_data;
          st_r.exl    <= cfg_data[ST_EXL];
        end
        CFG_COMPARE: st_r.compare          <= cfg_data;
        CFG_PTBASE:  st_r.context_w[31:23] <= cfg_data[8:0];
        CFG_ASID:    st_r.entryhi[12:0]    <= cfg_data[12:0];
      endcase
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // EXL only drops through a Status write
  a_exl_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.exl && !cfg_fire) |=> st_r.exl)
    else $error("EXL cleared without a status write");

  // an event that does not enter leaves EPC alone
  a_epc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !redir.taken && !cfg_fire) |=> (st_r.epc == $past(st_r.epc)))
    else $error("EPC changed without exception entry");

  // input side only stalls when its register is occupied
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a blocked output");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the COP0 exception entry unit
// Directed events first, then short random phases, each opening with a fresh
// Status setting and, at times, new Compare, PTBase and ASID values. A local COP0 model predicts every result beat.
// ----------------------------------------------------------------------------
module tb_top;
  import mee_pkg::*;

  localparam int unsigned RANDOM_EVENTS = 1825;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic        taken;
    logic [31:0] next_pc;
    logic [31:0] epc;
    logic [31:0] cause;
    logic [31:0] badvaddr;
    logic [31:0] ctx;
    logic [31:0] entryhi;
    logic [31:0] count;
    logic        exl;
  } entry_t;

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata   = '0;
  logic [2:0]   in_tuser   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [231:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index  = '0;
  logic [31:0]  cfg_data   = '0;

  // COP0 state as the model sees it
  logic [31:0] m_status   = STATUS_RESET;
  logic [31:0] m_compare  = '0;
  logic        m_exl      = 1'b0;
  logic [31:0] m_epc      = '0;
  logic [31:0] m_cause    = '0;
  logic [31:0] m_badvaddr = '0;
  logic [31:0] m_context  = '0;
  logic [31:0] m_entryhi  = '0;
  logic [31:0] m_count    = '0;

  item_t       pending_events[$];
  entry_t      expected_entries[$];
  item_t       drive_ev;
  entry_t      want_entry;
  int unsigned queued      = 0;
  int unsigned accepted    = 0;
  int unsigned errors      = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle   = 36;
  int unsigned recv_idle   = 67;

  mips_exception_entry_unit_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // COP0 model
  // --------------------------------------------------------------------------
  function automatic logic [31:0] enter_vector(logic [23:0] code, logic bd,
                                               logic [31:0] pc);
    logic [31:0] ofs;
    logic [23:0] sel;
    logic        boot;
    ofs     = OFS_TLB;
    m_cause = {16'h0, code[15:0]};
    if (!m_status[ST_ERL]) begin
      sel  = code & EXC_MASK;
      boot = m_status[ST_BEV];
      if (sel == CODE_TLBL || sel == CODE_TLBS) ofs = OFS_TLB;
      else if (sel == '0) ofs = OFS_INT;
      else ofs = OFS_GEN;
    end else begin
      sel  = code & ERL_MASK;
      boot = m_status[ST_DEV];
      // reset and NMI bypass EXL and EPC entirely
      if (sel <= ERL_RESET_MAX) return VEC_RESET;
      else if (sel == ERL_CODE_A) ofs = OFS_ERL_A;
      else if (sel == ERL_CODE_B) ofs = OFS_ERL_B;
    end
    if (!m_exl) begin
      m_exl            = 1'b1;
      m_status[ST_EXL] = 1'b1;
      m_epc            = bd ? pc - 32'd4 : pc;
      m_cause[31]      = bd;
    end else begin
      ofs = OFS_GEN;
    end
    return (boot ? VEC_BOOT : VEC_NORMAL) + ofs;
  endfunction

  function automatic entry_t predict_entry(item_t it);
    entry_t      e;
    logic [31:0] bound;
    e.taken   = 1'b0;
    e.next_pc = it.cur_pc;
    case (it.req_type)
      REQ_EXC: begin
        e.next_pc = enter_vector(it.exc_code, it.in_delay_slot, it.cur_pc);
        e.taken   = 1'b1;
      end
      REQ_TLBL, REQ_TLBS: begin
        m_badvaddr = it.fault_addr;
        m_context  = (m_context & CTX_KEEP) | ((it.fault_addr >> 9) & CTX_VPN);
        m_entryhi  = (it.fault_addr & EHI_VPN) | (m_entryhi & ~EHI_VPN);
        e.next_pc  = enter_vector((it.req_type == REQ_TLBL) ? CODE_TLBL : CODE_TLBS,
                                  it.in_delay_slot, it.cur_pc - 32'd4);
        e.taken    = 1'b1;
      end
      REQ_INT: begin
        if ((m_status & {8'h0, it.exc_code}) != '0 && m_status[ST_EIE] &&
            m_status[ST_IE] && !m_exl && !m_status[ST_ERL]) begin
          e.next_pc = enter_vector(it.exc_code, it.in_delay_slot, it.cur_pc);
          e.taken   = 1'b1;
        end
      end
      REQ_TICK: begin
        bound   = m_compare + TIMER_WINDOW;
        m_count = m_count + it.elapsed_cycles;
        if (m_status[ST_TIMER] && m_count >= m_compare && m_count < bound) begin
          e.next_pc = enter_vector(CODE_TIMER, it.in_delay_slot, it.cur_pc);
          e.taken   = 1'b1;
        end
      end
      default: ;
    endcase
    e.epc      = m_epc;
    e.cause    = m_cause;
    e.badvaddr = m_badvaddr;
    e.ctx      = m_context;
    e.entryhi  = m_entryhi;
    e.count    = m_count;
    e.exl      = m_exl;
    return e;
  endfunction

  function automatic void apply_cfg(logic [1:0] idx, logic [31:0] value);
    case (idx)
      CFG_STATUS: begin
        m_status = value;
        m_exl    = value[ST_EXL];
      end
      CFG_COMPARE: m_compare = value;
      CFG_PTBASE:  m_context = {value[8:0], m_context[22:0]};
      CFG_ASID:    m_entryhi = {m_entryhi[31:13], value[12:0]};
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Event driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_entries.push_back(predict_entry(drive_ev));
        accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle) begin
          drive_ev  = pending_events.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= drive_ev.req_type;
          in_tdata  <= {7'b0, drive_ev.elapsed_cycles, drive_ev.cur_pc,
                        drive_ev.fault_addr, drive_ev.in_delay_slot, drive_ev.exc_code};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (errors < 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_entries.size() == 0) begin
          if (errors < 10) $display("result beat with nothing pending: %h", out_tdata);
          errors++;
        end else begin
          want_entry = expected_entries.pop_front();
          check_field("taken",    {31'b0, want_entry.taken}, {31'b0, out_tuser[0]});
          check_field("next_pc",  want_entry.next_pc,  out_tdata[31:0]);
          check_field("epc",      want_entry.epc,      out_tdata[63:32]);
          check_field("cause",    want_entry.cause,    out_tdata[95:64]);
          check_field("badvaddr", want_entry.badvaddr, out_tdata[127:96]);
          check_field("context",  want_entry.ctx,      out_tdata[159:128]);
          check_field("entryhi",  want_entry.entryhi,  out_tdata[191:160]);
          check_field("count",    want_entry.count,    out_tdata[223:192]);
          check_field("exl",      {31'b0, want_entry.exl}, {31'b0, out_tdata[224]});
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, value);
    cfg_valid <= 1'b0;
  endtask

  function automatic item_t make_event(logic [2:0] req, logic [23:0] code, logic bd,
                                       logic [31:0] addr, logic [31:0] pc,
                                       logic [31:0] elapsed);
    item_t it;
    it.req_type       = req;
    it.exc_code       = code;
    it.in_delay_slot  = bd;
    it.fault_addr     = addr;
    it.cur_pc         = pc;
    it.elapsed_cycles = elapsed;
    return it;
  endfunction

  function automatic void queue_event(item_t it);
    pending_events.push_back(it);
    queued++;
  endfunction

  function automatic item_t random_event();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 25) it.req_type = REQ_EXC;
    else if (pick < 37) it.req_type = REQ_TLBL;
    else if (pick < 49) it.req_type = REQ_TLBS;
    else if (pick < 69) it.req_type = REQ_INT;
    else if (pick < 94) it.req_type = REQ_TICK;
    else it.req_type = REQ_TICK + 3'($urandom_range(1, 3));
    it.exc_code = 24'($urandom());
    // a single pending line hits the mask bits more often
    if (it.req_type == REQ_INT && $urandom_range(1) == 1)
      it.exc_code = 24'(1) << $urandom_range(23);
    it.in_delay_slot  = 1'($urandom_range(1));
    it.fault_addr     = $urandom();
    it.cur_pc         = $urandom();
    it.elapsed_cycles = ($urandom_range(99) < 70) ? $urandom_range(0, 700) : $urandom();
    return it;
  endfunction

  task automatic random_settings();
    logic [31:0] st;
    logic [31:0] cmp;
    st = $urandom();
    if ($urandom_range(99) < 80) st[ST_EXL] = 1'b0;
    if ($urandom_range(99) < 70) st[ST_ERL] = 1'b0;
    if ($urandom_range(99) < 60) begin
      st[ST_IE]  = 1'b1;
      st[ST_EIE] = 1'b1;
    end
    cfg_write(CFG_STATUS, st);
    if ($urandom_range(99) < 40) begin
      case ($urandom_range(3))
        0: cmp = $urandom();
        // upper bound wraps: empty window
        1: cmp = 32'hFFFF_FC18 + $urandom_range(0, 999);
        default: cmp = m_count + $urandom_range(0, 1500);
      endcase
      cfg_write(CFG_COMPARE, cmp);
    end
    if ($urandom_range(99) < 25) cfg_write(CFG_PTBASE, $urandom_range(0, 511));
    if ($urandom_range(99) < 25) cfg_write(CFG_ASID, $urandom_range(0, 8191));
  endtask

  // hold until every event is back, then let the pipeline settle
  task automatic drain();
    while (accepted != queued || expected_entries.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned total;
    int unsigned n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset Status: ERL and BEV set
    queue_event(make_event(REQ_EXC, 24'h000000, 1'b0, 32'h0, 32'hFFFF_FFFF, 32'h0));
    queue_event(make_event(REQ_EXC, 24'h008000, 1'b1, 32'h0, 32'h0000_1000, 32'h0));
    queue_event(make_event(REQ_EXC, 24'h010000, 1'b1, 32'h0, 32'h0000_0000, 32'h0));
    queue_event(make_event(REQ_EXC, 24'h018000, 1'b0, 32'h0, 32'h0000_2000, 32'h0));
    queue_event(make_event(REQ_TICK + 3'd1, 24'hFFFFFF, 1'b1, 32'hFFFF_FFFF, 32'h1234_5678,
                           32'hFFFF_FFFF));
    queue_event(make_event(REQ_TICK + 3'd2, 24'h000000, 1'b0, 32'h0, 32'h0, 32'h0));
    queue_event(make_event(REQ_TICK + 3'd3, 24'hFFFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF));
    queue_event(make_event(REQ_TLBL, 24'h0, 1'b0, 32'hFFFF_FFFF, 32'h8000_0400, 32'h0));
    queue_event(make_event(REQ_INT, 24'hFFFFFF, 1'b0, 32'h0, 32'h0000_0040, 32'h0));
    queue_event(make_event(REQ_TICK, 24'h0, 1'b0, 32'h0, 32'h0000_0080, 32'h0));
    drain();

    // ERL with DEV: boot vector, then a TLB store that takes the reset vector
    cfg_write(CFG_STATUS, 32'h0080_0004);
    cfg_write(CFG_COMPARE, 32'h0);
    cfg_write(CFG_PTBASE, 32'd511);
    cfg_write(CFG_ASID, 32'd8191);
    queue_event(make_event(REQ_EXC, 24'h018000, 1'b0, 32'h0, 32'h0000_3000, 32'h0));
    queue_event(make_event(REQ_TLBS, 24'h0, 1'b1, 32'h1234_5678, 32'h0000_3004, 32'h0));
    drain();

    // normal level, BEV set; count lands on the edge of a wrapped window
    cfg_write(CFG_STATUS, 32'h0041_8C01);
    cfg_write(CFG_COMPARE, 32'hFFFF_FFFF);
    cfg_write(CFG_PTBASE, 32'd0);
    cfg_write(CFG_ASID, 32'd0);
    queue_event(make_event(REQ_INT, 24'h000400, 1'b1, 32'h0, 32'h0000_4000, 32'h0));
    queue_event(make_event(REQ_TICK, 24'h0, 1'b0, 32'h0, 32'h0000_4004, 32'hFFFF_FFFF));
    drain();

    // count wraps into the timer window
    cfg_write(CFG_STATUS, 32'h0001_8C01);
    cfg_write(CFG_COMPARE, 32'd5);
    queue_event(make_event(REQ_TICK, 24'h0, 1'b1, 32'h0, 32'h0000_5000, 32'd6));
    queue_event(make_event(REQ_TLBL, 24'h0, 1'b0, 32'h0000_0000, 32'h0000_5004, 32'h0));
    drain();

    cfg_write(CFG_STATUS, 32'h0001_8C01);
    queue_event(make_event(REQ_TLBS, 24'h0, 1'b1, 32'h8000_1234, 32'h0000_6000, 32'h0));
    queue_event(make_event(REQ_EXC, 24'h000004, 1'b0, 32'h0, 32'h0000_6004, 32'h0));
    drain();

    cfg_write(CFG_STATUS, 32'hFFFF_FFFF);
    queue_event(make_event(REQ_INT, 24'hFFFFFF, 1'b0, 32'h0, 32'h0000_7000, 32'h0));
    queue_event(make_event(REQ_EXC, 24'h00007C, 1'b1, 32'h0, 32'h0000_7004, 32'h0));
    drain();

    cfg_write(CFG_STATUS, 32'h0);
    queue_event(make_event(REQ_EXC, 24'h000004, 1'b1, 32'h0, 32'h0000_8000, 32'h0));
    queue_event(make_event(REQ_INT, 24'hFFFFFF, 1'b0, 32'h0, 32'h0000_8004, 32'h0));
    queue_event(make_event(REQ_TICK, 24'h0, 1'b0, 32'h0, 32'h0000_8008, 32'd1));
    drain();

    // short phases, each reopening Status so EXL can be cleared again
    total = 0;
    while (total < RANDOM_EVENTS) begin
      if (total < RANDOM_EVENTS / 3) begin
        send_idle = 36;
        recv_idle = 67;
      end else if (total < 2 * RANDOM_EVENTS / 3) begin
        send_idle = 67;
        recv_idle = 36;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      random_settings();
      n = $urandom_range(1, 24);
      repeat (n) queue_event(random_event());
      total += n;
      drain();
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
